/* design/rau_pkg.sv */
package rau_pkg;

  localparam int DataW    = 32;
  localparam int WidthDef = 32;
  localparam int QDepth   = 2;
  localparam int QPtrW    = $clog2(QDepth);

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatOvf     = 2'd1;
  localparam logic [1:0] StatDenZero = 2'd2;

  localparam logic [2:0] OpcAdd  = 3'd0;
  localparam logic [2:0] OpcSub  = 3'd1;
  localparam logic [2:0] OpcMul  = 3'd2;
  localparam logic [2:0] OpcDiv  = 3'd3;
  localparam logic [2:0] OpcSimp = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SIMP,
    OP_PASS
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_GCD,
    S_DIV,
    S_FIN
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [DataW-1:0]  an;
    logic [DataW-1:0]  ad;
    logic [DataW-1:0]  bn;
    logic [DataW-1:0]  bd;
  } item_t;

endpackage

/* design/rau_front.sv */
module rau_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                operation_i,
  input  logic [rau_pkg::DataW-1:0] a_numerator_i,
  input  logic [rau_pkg::DataW-1:0] a_denominator_i,
  input  logic [rau_pkg::DataW-1:0] b_numerator_i,
  input  logic [rau_pkg::DataW-1:0] b_denominator_i,
  output logic                      q_valid_o,
  output rau_pkg::item_t            q_item_o,
  input  logic                      q_pop_i
);

  rau_pkg::item_t                mem_q [rau_pkg::QDepth];
  rau_pkg::item_t                item_d;
  logic [rau_pkg::QPtrW-1:0]     wr_q, rd_q;
  logic [rau_pkg::QPtrW:0]       cnt_q;
  logic                          push, pop;

  always_comb begin
    case (operation_i)
      rau_pkg::OpcAdd:  item_d.op = rau_pkg::OP_ADD;
      rau_pkg::OpcSub:  item_d.op = rau_pkg::OP_SUB;
      rau_pkg::OpcMul:  item_d.op = rau_pkg::OP_MUL;
      rau_pkg::OpcDiv:  item_d.op = rau_pkg::OP_DIV;
      rau_pkg::OpcSimp: item_d.op = rau_pkg::OP_SIMP;
      default:          item_d.op = rau_pkg::OP_PASS;
    endcase
    item_d.an = a_numerator_i;
    item_d.bn = b_numerator_i;
    item_d.ad = (a_denominator_i == '0) ? rau_pkg::DataW'(1) : a_denominator_i;
    item_d.bd = (b_denominator_i == '0) ? rau_pkg::DataW'(1) : b_denominator_i;
  end

  assign in_stall_o = (cnt_q == (rau_pkg::QPtrW+1)'(rau_pkg::QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

/* design/rau_back.sv */
module rau_back #(
  parameter int WIDTH = rau_pkg::WidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  rau_pkg::item_t            q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rau_pkg::DataW-1:0] result_numerator_o,
  output logic [rau_pkg::DataW-1:0] result_denominator_o,
  output logic [1:0]                status_o
);

  localparam int W = (WIDTH < 1) ? 1 : ((WIDTH > 64) ? 64 : WIDTH);
  localparam logic [63:0] WMask  = {64{1'b1}} >> (64 - W);
  localparam logic [63:0] HiMask = ~((64'd1 << (W - 1)) - 64'd1);

  rau_pkg::state_e state_q, state_d;
  rau_pkg::item_t  it_q;
  logic [1:0]      step_q;
  logic [63:0]     p0_q, p1_q, p2_q;
  logic [31:0]     x_q, y_q;
  logic [4:0]      k_q;
  logic [31:0]     g_q, na_q, nd_q, ra_q, rd_q;
  logic [4:0]      dcnt_q;
  logic            out_valid_q;
  logic [31:0]     res_n_q, res_d_q;
  logic [1:0]      stat_q;

  logic            out_free, take;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod;
  logic [31:0]     mag_an, mag_ad;
  logic [32:0]     ra_sh, rd_sh;
  logic            ra_ge, rd_ge;
  logic [64:0]     sum65;
  logic [63:0]     rn_bits, rn_t, rd_t;
  logic            rn_ovf, fit_n, fit_d;
  logic [63:0]     pres_n, pres_d;
  logic [1:0]      stat_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = q_valid_i && (state_q == rau_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rau_pkg::S_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.op == rau_pkg::OP_SIMP)      state_d = rau_pkg::S_GCD;
          else if (q_item_i.op == rau_pkg::OP_PASS) state_d = rau_pkg::S_FIN;
          else                                      state_d = rau_pkg::S_MUL;
        end
      end
      rau_pkg::S_MUL: if (step_q == 2'd2) state_d = rau_pkg::S_FIN;
      rau_pkg::S_GCD: if (x_q == '0) state_d = rau_pkg::S_DIV;
      rau_pkg::S_DIV: if (dcnt_q == '0) state_d = rau_pkg::S_FIN;
      rau_pkg::S_FIN: if (out_free) state_d = rau_pkg::S_IDLE;
      default:        state_d = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = take;
  end

  assign mag_an = it_q.an[31] ? (32'd0 - it_q.an) : it_q.an;
  assign mag_ad = it_q.ad[31] ? (32'd0 - it_q.ad) : it_q.ad;

  always_comb begin
    mul_a = it_q.an;
    mul_b = it_q.bd;
    case (step_q)
      2'd0: if (it_q.op == rau_pkg::OP_MUL) mul_b = it_q.bn;
      2'd1: begin
        mul_a = it_q.bn;
        mul_b = it_q.ad;
      end
      default: begin
        mul_a = it_q.ad;
        mul_b = (it_q.op == rau_pkg::OP_DIV) ? it_q.bn : it_q.bd;
      end
    endcase
  end

  assign prod = 64'($signed(mul_a) * $signed(mul_b));

  assign ra_sh = {ra_q, na_q[31]};
  assign rd_sh = {rd_q, nd_q[31]};
  assign ra_ge = (ra_sh >= {1'b0, g_q});
  assign rd_ge = (rd_sh >= {1'b0, g_q});

  always_comb begin
    sum65   = {p0_q[63], p0_q} + {p1_q[63], p1_q};
    rn_ovf  = 1'b0;
    case (it_q.op)
      rau_pkg::OP_ADD: begin
        rn_bits = sum65[63:0];
        rn_ovf  = (p0_q[63] == p1_q[63]) && (sum65[63] != p0_q[63]);
      end
      rau_pkg::OP_SUB: rn_bits = p0_q - p1_q;
      default:         rn_bits = p0_q;
    endcase
    rn_t   = rn_bits & HiMask;
    rd_t   = p2_q & HiMask;
    fit_n  = !rn_ovf && ((rn_t == '0) || (rn_t == HiMask));
    fit_d  = (rd_t == '0) || (rd_t == HiMask);
    pres_n = rn_bits & WMask;
    pres_d = p2_q & WMask;
    if (pres_n[W-1]) pres_n = pres_n | ~WMask;
    if (pres_d[W-1]) pres_d = pres_d | ~WMask;
    if ((p2_q & WMask) == '0)  stat_d = rau_pkg::StatDenZero;
    else if (!fit_n || !fit_d) stat_d = rau_pkg::StatOvf;
    else                       stat_d = rau_pkg::StatOk;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      it_q   <= q_item_i;
      step_q <= 2'd0;
      k_q    <= '0;
      x_q    <= q_item_i.an[31] ? (32'd0 - q_item_i.an) : q_item_i.an;
      y_q    <= q_item_i.ad[31] ? (32'd0 - q_item_i.ad) : q_item_i.ad;
      if (q_item_i.op == rau_pkg::OP_PASS) begin
        p0_q <= 64'($signed(q_item_i.an));
        p2_q <= 64'($signed(q_item_i.ad));
      end
    end
    case (state_q)
      rau_pkg::S_IDLE: ;
      rau_pkg::S_MUL: begin
        step_q <= step_q + 2'd1;
        case (step_q)
          2'd0:    p0_q <= prod;
          2'd1:    p1_q <= prod;
          default: p2_q <= prod;
        endcase
      end
      rau_pkg::S_GCD: begin
        if (x_q == '0) begin
          g_q    <= y_q << k_q;
          na_q   <= mag_an;
          nd_q   <= mag_ad;
          ra_q   <= '0;
          rd_q   <= '0;
          dcnt_q <= 5'd31;
        end else if (!x_q[0] && !y_q[0]) begin
          x_q <= x_q >> 1;
          y_q <= y_q >> 1;
          k_q <= k_q + 5'd1;
        end else if (!x_q[0]) begin
          x_q <= x_q >> 1;
        end else if (!y_q[0]) begin
          y_q <= y_q >> 1;
        end else if (x_q >= y_q) begin
          x_q <= x_q - y_q;
        end else begin
          y_q <= y_q - x_q;
        end
      end
      rau_pkg::S_DIV: begin
        dcnt_q <= dcnt_q - 5'd1;
        ra_q   <= ra_ge ? 32'(ra_sh - {1'b0, g_q}) : ra_sh[31:0];
        rd_q   <= rd_ge ? 32'(rd_sh - {1'b0, g_q}) : rd_sh[31:0];
        na_q   <= {na_q[30:0], ra_ge};
        nd_q   <= {nd_q[30:0], rd_ge};
        if (dcnt_q == '0) begin
          p0_q <= it_q.an[31] ? (64'd0 - {32'd0, na_q[30:0], ra_ge})
                              : {32'd0, na_q[30:0], ra_ge};
          p2_q <= it_q.ad[31] ? (64'd0 - {32'd0, nd_q[30:0], rd_ge})
                              : {32'd0, nd_q[30:0], rd_ge};
        end
      end
      rau_pkg::S_FIN: begin
        if (out_free) begin
          res_n_q <= pres_n[31:0];
          res_d_q <= pres_d[31:0];
          stat_q  <= stat_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rau_pkg::S_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)                     out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign result_numerator_o   = res_n_q;
  assign result_denominator_o = res_d_q;
  assign status_o             = stat_q;

endmodule

/* design/rational_arithmetic_unit_top.sv */
// Rational arithmetic on operand pairs given as numerator and denominator: add, subtract,
// multiply, divide, and simplify of the left operand by the gcd of its parts. A zero input
// denominator counts as one; results are not reduced, wrap to WIDTH bits and report overflow
// or a zero denominator in status. A two-entry queue holds accepted transfers while the back
// end works. Add, subtract, multiply and divide hold the back end for a take in the idle
// state, three passes through one shared 32x32 multiplier and a finish state; unused
// operation codes pass the left operand through a take and the finish state; simplify runs
// a binary gcd loop of one step per cycle followed by a bit-serial divider over 32 bits.
module rational_arithmetic_unit_top #(
  parameter int WIDTH = rau_pkg::WidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [2:0]                operation_i,
  input  logic [rau_pkg::DataW-1:0] a_numerator_i,
  input  logic [rau_pkg::DataW-1:0] a_denominator_i,
  input  logic [rau_pkg::DataW-1:0] b_numerator_i,
  input  logic [rau_pkg::DataW-1:0] b_denominator_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rau_pkg::DataW-1:0] result_numerator_o,
  output logic [rau_pkg::DataW-1:0] result_denominator_o,
  output logic [1:0]                status_o
);

  logic           q_valid, q_pop;
  rau_pkg::item_t q_item;

  rau_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .a_numerator_i   (a_numerator_i),
    .a_denominator_i (a_denominator_i),
    .b_numerator_i   (b_numerator_i),
    .b_denominator_i (b_denominator_i),
    .q_valid_o       (q_valid),
    .q_item_o        (q_item),
    .q_pop_i         (q_pop)
  );

  rau_back #(
    .WIDTH (WIDTH)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_valid_i            (q_valid),
    .q_item_i             (q_item),
    .q_pop_o              (q_pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .result_numerator_o   (result_numerator_o),
    .result_denominator_o (result_denominator_o),
    .status_o             (status_o)
  );

endmodule
